// ===== hw/rtl/rrbi_pkg.sv =====
package rrbi_pkg;

	localparam int CoordW = 24;
	localparam int SizeW  = 23;
	localparam int DiffW  = 25;
	localparam int MagW   = 24;
	localparam int HalfW  = 22;
	localparam int NumW   = 46;
	localparam int QuoW   = 46;
	localparam int RemW   = 25;
	localparam int DivSteps = 46;
	localparam int InW  = 144;
	localparam int OutW = 56;
	localparam logic signed [CoordW-1:0] SatMax = 24'sh7FFFFF;
	localparam logic signed [CoordW-1:0] SatMin = -24'sh800000;

	// work item carried along the divider chain
	typedef struct packed {
		logic                     in_rect;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic                     div_x;
		logic                     neg;
		logic signed [CoordW-1:0] fixed_t;
		logic [NumW-1:0]          num;
		logic [MagW-1:0]          den;
		logic [RemW-1:0]          rem;
		logic [QuoW-1:0]          quo;
	} rrbi_item_t;

endpackage

// ===== hw/rtl/rrbi_prep.sv =====
module rrbi_prep (
	input  logic                   clk,
	input  logic                   en,
	input  logic [rrbi_pkg::InW-1:0] din,
	output rrbi_pkg::rrbi_item_t  item
);
	import rrbi_pkg::*;

	logic signed [CoordW-1:0] cx, cy, px, py;
	logic [SizeW-1:0] w, h;
	logic signed [DiffW-1:0] dx, dy;
	logic [MagW-1:0] adx, ady;
	logic [HalfW-1:0] hw, hh;
	logic [47:0] lhs, rhs;
	rrbi_item_t n;

	assign cx = din[23:0];
	assign cy = din[47:24];
	assign w  = din[70:48];
	assign h  = din[93:71];
	assign px = din[117:94];
	assign py = din[141:118];

	always_comb begin
		dx = DiffW'(px) - DiffW'(cx);
		dy = DiffW'(py) - DiffW'(cy);
		adx = dx[DiffW-1] ? MagW'(-dx) : MagW'(dx);
		ady = dy[DiffW-1] ? MagW'(-dy) : MagW'(dy);
		hw = w[SizeW-1:1];
		hh = h[SizeW-1:1];
		lhs = adx * h;
		rhs = ady * w;
		n = '0;
		n.px = px;
		n.py = py;
		n.cx = cx;
		n.cy = cy;
		n.in_rect = ({adx, 1'b0} < {2'b0, w}) && ({ady, 1'b0} < {2'b0, h});
		if (dx == '0) begin
			n.div_x = 1'b1;
			n.fixed_t = dy[DiffW-1] ? -CoordW'(hh) : CoordW'(hh);
		end else if (dy == '0) begin
			n.div_x = 1'b0;
			n.fixed_t = dx[DiffW-1] ? -CoordW'(hw) : CoordW'(hw);
		end else if (lhs >= rhs) begin
			// vertical side: ty = tx*dy/dx
			n.div_x = 1'b0;
			n.fixed_t = dx[DiffW-1] ? -CoordW'(hw) : CoordW'(hw);
			n.num = NumW'(hw) * NumW'(ady);
			n.den = adx;
			n.neg = dy[DiffW-1];
		end else begin
			n.div_x = 1'b1;
			n.fixed_t = dy[DiffW-1] ? -CoordW'(hh) : CoordW'(hh);
			n.num = NumW'(hh) * NumW'(adx);
			n.den = ady;
			n.neg = dx[DiffW-1];
		end
		if (n.den == '0) n.den = MagW'(1);
	end

	// input register
	always_ff @(posedge clk) begin
		if (en) item <= n;
	end
endmodule

// ===== hw/rtl/rrbi_cell.sv =====
module rrbi_cell (
	input  logic                  clk,
	input  logic                  en,
	input  rrbi_pkg::rrbi_item_t  din,
	output rrbi_pkg::rrbi_item_t  dout
);
	import rrbi_pkg::*;

	logic [RemW-1:0] sh;
	logic [RemW-1:0] diff;
	rrbi_item_t n;

	// one restoring division step, numerator bit shifted in from the top
	always_comb begin
		n = din;
		sh = {din.rem[RemW-2:0], din.num[NumW-1]};
		diff = sh - RemW'(din.den);
		n.num = {din.num[NumW-2:0], 1'b0};
		if (sh >= RemW'(din.den)) begin
			n.rem = diff;
			n.quo = {din.quo[QuoW-2:0], 1'b1};
		end else begin
			n.rem = sh;
			n.quo = {din.quo[QuoW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) dout <= n;
	end
endmodule

// ===== hw/rtl/rrbi_post.sv =====
module rrbi_post (
	input  rrbi_pkg::rrbi_item_t   item,
	output logic [rrbi_pkg::OutW-1:0] dout
);
	import rrbi_pkg::*;

	logic signed [DiffW-1:0] q;
	logic signed [DiffW-1:0] tx, ty, sx, sy;
	logic signed [CoordW-1:0] ox, oy;

	// quotient fits 25 bits since |other offset| <= half extent
	always_comb begin
		q = item.neg ? -DiffW'(item.quo) : DiffW'(item.quo);
		if (item.div_x) begin
			tx = q;
			ty = DiffW'(item.fixed_t);
		end else begin
			tx = DiffW'(item.fixed_t);
			ty = q;
		end
		sx = DiffW'(item.cx) + tx;
		sy = DiffW'(item.cy) + ty;
		ox = (sx > DiffW'(SatMax)) ? SatMax : (sx < DiffW'(SatMin)) ? SatMin : CoordW'(sx);
		oy = (sy > DiffW'(SatMax)) ? SatMax : (sy < DiffW'(SatMin)) ? SatMin : CoordW'(sy);
		if (item.in_rect) begin
			ox = item.px;
			oy = item.py;
		end
		dout = {7'b0, item.in_rect, oy, ox};
	end
endmodule

// ===== hw/rtl/ray_rect_boundary_intersect_top.sv =====
// Pipeline: 1 prep stage, 46 divider cells and 1 output register from input beat to
// output beat.
// Throughput: one beat per cycle; the whole pipeline advances when the output is free.
// Reset: arst_n clears all valid flags; payload registers are not reset.
module ray_rect_boundary_intersect_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// cx, cy, rect_width, rect_height, point_x, point_y (lowest first), zero pad
	input  logic [rrbi_pkg::InW-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// cross_x, cross_y, point_inside (lowest first), zero pad
	output logic [rrbi_pkg::OutW-1:0]  m_tdata
);
	import rrbi_pkg::*;

	localparam int Stages = DivSteps + 2;

	logic en;
	logic [Stages-1:0] vld_q;
	rrbi_item_t chain [0:DivSteps];
	logic [OutW-1:0] res;

	// stall the whole chain only when the output holds an untaken beat
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[Stages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Stages-2:0], s_tvalid};
		end
	end

	rrbi_prep u_prep (.clk(clk), .en(en), .din(s_tdata), .item(chain[0]));

	for (genvar i = 0; i < DivSteps; i++) begin : g_cell
		rrbi_cell u_cell (.clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1]));
	end

	rrbi_post u_post (.item(chain[DivSteps]), .dout(res));

	always_ff @(posedge clk) begin
		if (en) m_tdata <= res;
	end
endmodule

// ===== hw/rtl/rrbi_checker.sv =====
module rrbi_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [rrbi_pkg::OutW-1:0] m_tdata
);
	import rrbi_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OutW-1:49] == '0)
		else $error("pad bits set");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown(m_tdata))
		else $error("unknown bits in output beat");
endmodule

bind ray_rect_boundary_intersect_top rrbi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
